@@ rtl/frustum_cull_test_macros.svh @@
// Assertion macros of the frustum cull test RTL.
// Depends on nothing; included by fct_cell, which carries the assertions.
`ifndef FRUSTUM_CULL_TEST_MACROS_SVH
`define FRUSTUM_CULL_TEST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum cull test: check failed");

// Next-cycle implication, checked out of reset.
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum cull test: check failed");

`endif

@@ rtl/fct_pkg.sv @@
// Shared types and constants of the frustum cull test.
// Used by fct_regs, fct_cell and frustum_cull_test; depends on nothing.
package fct_pkg;

    localparam int NUM_REGS = 6;
    localparam int PLANE_W  = 64;
    localparam int ADDR_W   = 6;
    localparam int AX_W     = 16;
    localparam int LEN_W    = 16;

    typedef enum logic [1:0] {
        ACT_POINT  = 2'd0,
        ACT_SPHERE = 2'd1,
        ACT_BOX    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        POS_FRONT = 2'd0,
        POS_SPAN  = 2'd1,
        POS_BACK  = 2'd2
    } t_pos;

    typedef struct packed {
        logic in_view;
        t_pos pos;
    } t_status;

    typedef struct packed {
        t_action                    action;
        logic [LEN_W-1:0]           radius;
        logic [2:0][3*AX_W-1:0]     axis;
        logic [2:0][LEN_W-1:0]      half_len;
        t_status                    st;
    } t_query;

    typedef logic [PLANE_W-1:0] t_plane;

endpackage

@@ rtl/fct_regs.sv @@
// Plane register bank behind the APB-style configuration port.
// Depends on fct_pkg.
module fct_regs import fct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PLANE_W-1:0]  pwdata,
    output logic [PLANE_W-1:0]  prdata,
    output logic                pready,
    output t_plane              o_planes [NUM_REGS]
);

    logic [2:0] w_idx;
    logic       w_hit;
    t_plane     r_plane [NUM_REGS];

    // decode the 64-bit register slot
    assign w_idx  = paddr[ADDR_W-1:3];
    assign w_hit  = (w_idx < 3'(NUM_REGS)) && (paddr[2:0] == 3'd0 || paddr[2:0] != 3'd0);
    assign pready = 1'b1;

    // write on the access phase, drop writes beyond the bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_plane[i] <= '0;
            end
        end else if (psel && penable && pwrite && w_hit) begin
            r_plane[w_idx] <= pwdata;
        end
    end

    // read back
    assign prdata = w_hit ? r_plane[w_idx] : '0;

    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            o_planes[i] = r_plane[i];
        end
    end

endmodule

@@ rtl/fct_cell.sv @@
// One plane cell of the culling chain: four pipeline stages that test a
// query against one plane and hand it on. Depends on fct_pkg and the macros.
`include "frustum_cull_test_macros.svh"

module fct_cell import fct_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_plane                  i_plane,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_query                  i_q,
    input  logic [3*COORD_BITS-1:0] i_center,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_query                  o_q,
    output logic [3*COORD_BITS-1:0] o_center
);

    localparam int STAGES = 4;
    localparam int CW     = 3*COORD_BITS;
    localparam int PD_W   = COORD_BITS + AX_W;
    localparam int DIST_W = COORD_BITS + 18;
    localparam int PN_W   = 2*AX_W;
    localparam int DOT_W  = PN_W + 2;
    localparam int ABS_W  = PN_W;
    localparam int EK_W   = ABS_W + LEN_W;
    localparam int EXT_W  = EK_W + 2;
    localparam int CMP_W  = ((COORD_BITS + 31 > EXT_W) ? COORD_BITS + 31 : EXT_W) + 2;
    localparam logic signed [CMP_W-1:0] ONE_Q30 = CMP_W'(1) << 30;

    // plane fields
    logic signed [AX_W-1:0] w_n [3];
    logic signed [AX_W-1:0] w_d;

    // stage handshake and carried query
    logic          r_v [STAGES];
    logic          w_rdy [STAGES];
    t_query        r_q [STAGES];
    logic [CW-1:0] r_c [STAGES];

    // stage 1: products
    logic signed [COORD_BITS-1:0] w_cl [3];
    logic signed [AX_W-1:0]       w_ax [3][3];
    logic signed [PD_W-1:0]       n_s1_pd [3];
    logic signed [PN_W-1:0]       n_s1_pn [3][3];
    logic signed [PD_W-1:0]       r_s1_pd [3];
    logic signed [PN_W-1:0]       r_s1_pn [3][3];

    // stage 2: distance and absolute dot products
    logic signed [DIST_W-1:0] n_s2_dist;
    logic signed [DOT_W-1:0]  w_dot [3];
    logic [ABS_W-1:0]         n_s2_abs [3];
    logic signed [DIST_W-1:0] r_s2_dist;
    logic [ABS_W-1:0]         r_s2_abs [3];

    // stage 3: extent terms
    logic [EK_W-1:0]          n_s3_ek [3];
    logic signed [DIST_W-1:0] r_s3_dist;
    logic [EK_W-1:0]          r_s3_ek [3];

    // stage 4: extent sum
    logic [EXT_W-1:0]         n_s4_ext;
    logic signed [DIST_W-1:0] r_s4_dist;
    logic [EXT_W-1:0]         r_s4_ext;

    // hand-off compare
    logic signed [CMP_W-1:0] w_d17;
    logic signed [CMP_W-1:0] w_d30;
    logic signed [CMP_W-1:0] w_ext;
    logic signed [CMP_W-1:0] w_radx;
    logic                    w_le_pos;
    logic                    w_le_neg;
    logic                    w_back;
    t_status                 n_st;

    // unpack plane and lanes
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_n[j]  = i_plane[j*AX_W +: AX_W];
            w_cl[j] = i_center[j*COORD_BITS +: COORD_BITS];
            for (int k = 0; k < 3; k++) begin
                w_ax[k][j] = i_q.axis[k][j*AX_W +: AX_W];
            end
        end
        w_d = i_plane[3*AX_W +: AX_W];
    end

    // stage 1 products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_s1_pd[j] = w_n[j] * w_cl[j];
            for (int k = 0; k < 3; k++) begin
                n_s1_pn[k][j] = w_n[j] * w_ax[k][j];
            end
        end
    end

    // stage 2 sums
    always_comb begin
        n_s2_dist = DIST_W'(r_s1_pd[0]) + DIST_W'(r_s1_pd[1]) + DIST_W'(r_s1_pd[2])
                  + (DIST_W'(w_d) <<< 13);
        for (int k = 0; k < 3; k++) begin
            w_dot[k]    = DOT_W'(r_s1_pn[k][0]) + DOT_W'(r_s1_pn[k][1])
                        + DOT_W'(r_s1_pn[k][2]);
            n_s2_abs[k] = w_dot[k][DOT_W-1] ? ABS_W'(-w_dot[k]) : ABS_W'(w_dot[k]);
        end
    end

    // stage 3 scale by half lengths
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s3_ek[k] = EK_W'(r_s2_abs[k]) * EK_W'(r_q[1].half_len[k]);
        end
    end

    // stage 4 extent sum
    assign n_s4_ext = EXT_W'(r_s3_ek[0]) + EXT_W'(r_s3_ek[1]) + EXT_W'(r_s3_ek[2]);

    // backpressure chain: a stage loads when empty or when it drains
    always_comb begin
        w_rdy[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int j = STAGES-2; j >= 0; j--) begin
            w_rdy[j] = !r_v[j] || w_rdy[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < STAGES; j++) begin
                r_v[j] <= 1'b0;
            end
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < STAGES; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_q[0]  <= i_q;
            r_c[0]  <= i_center;
            r_s1_pd <= n_s1_pd;
            r_s1_pn <= n_s1_pn;
        end
        if (w_rdy[1]) begin
            r_q[1]    <= r_q[0];
            r_c[1]    <= r_c[0];
            r_s2_dist <= n_s2_dist;
            r_s2_abs  <= n_s2_abs;
        end
        if (w_rdy[2]) begin
            r_q[2]    <= r_q[1];
            r_c[2]    <= r_c[1];
            r_s3_dist <= r_s2_dist;
            r_s3_ek   <= n_s3_ek;
        end
        if (w_rdy[3]) begin
            r_q[3]    <= r_q[2];
            r_c[3]    <= r_c[2];
            r_s4_dist <= r_s3_dist;
            r_s4_ext  <= n_s4_ext;
        end
    end

    // compare against this plane
    assign w_d17    = CMP_W'(r_s4_dist);
    assign w_d30    = w_d17 <<< 13;
    assign w_ext    = CMP_W'(r_s4_ext);
    assign w_radx   = CMP_W'(r_q[3].radius) << 13;
    assign w_le_pos = w_d30 <= w_ext;
    assign w_le_neg = w_d30 <= -w_ext;
    assign w_back   = (w_d30 + ONE_Q30) < -w_ext;

    // update the running verdict
    always_comb begin
        n_st = r_q[3].st;
        unique case (r_q[3].action)
            ACT_POINT: begin
                if (w_d17 < 0) begin
                    n_st.in_view = 1'b0;
                end
            end
            ACT_SPHERE: begin
                if (w_d17 <= -w_radx) begin
                    n_st.in_view = 1'b0;
                end
            end
            ACT_BOX: begin
                if (w_le_neg) begin
                    n_st.in_view = 1'b0;
                end
                if (r_q[3].st.pos != POS_BACK) begin
                    if (w_back) begin
                        n_st.pos = POS_BACK;
                    end else if (w_le_pos) begin
                        n_st.pos = POS_SPAN;
                    end
                end
            end
            default: begin
                n_st = r_q[3].st;
            end
        endcase
    end

    always_comb begin
        o_q    = r_q[3];
        o_q.st = n_st;
    end

    assign o_center = r_c[3];
    assign o_valid  = r_v[STAGES-1];
    assign o_ready  = w_rdy[0];

    // a rejected query never comes back into view
    `FCT_ASSERT_NOW(a_inside_sticky, i_clk, i_rst_n,
        o_valid && !r_q[3].st.in_view, !o_q.st.in_view)
    // back class is final
    `FCT_ASSERT_NOW(a_back_sticky, i_clk, i_rst_n,
        o_valid && r_q[3].st.pos == POS_BACK, o_q.st.pos == POS_BACK)
    // only boxes get a class
    `FCT_ASSERT_NOW(a_class_box_only, i_clk, i_rst_n,
        o_valid && r_q[3].action != ACT_BOX, o_q.st.pos == r_q[3].st.pos)
    // a stalled last stage keeps its request
    `FCT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        r_v[STAGES-1] && !i_ready, r_v[STAGES-1] && $stable(r_s4_ext))

endmodule

@@ rtl/frustum_cull_test.sv @@
// Frustum cull test top level: plane registers, chain of plane cells and
// output register. Depends on fct_pkg, fct_regs and fct_cell.
//
// Tests one point, sphere or oriented-box query per clock against
// PLANE_COUNT clip planes held in registers plane_0..plane_5 (64-bit APB
// registers at byte addresses 8*i; A,B,C Q2.13 and D Q12.4 from low to high
// bits). Each plane has its own cell of four pipeline stages (products, sums,
// half-length scaling, extent sum), and an output register follows the last
// cell, so a query passes the stages of every cell and then the output
// register before o_valid rises, and one query is taken every cycle while
// the result side keeps up. Each result carries an inside flag and, for boxes
// only, a front, spanning or back class; an unused query kind yields outside
// and front. Planes beyond the sixth read as all zero. Write the planes only
// while no query is in flight.
module frustum_cull_test import fct_pkg::*; #(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PLANE_W-1:0]  pwdata,
    output logic [PLANE_W-1:0]  prdata,
    output logic                pready,
    // query request
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic [47:0]         i_center,
    input  logic [LEN_W-1:0]    i_radius,
    input  logic [47:0]         i_axis_0,
    input  logic [47:0]         i_axis_1,
    input  logic [47:0]         i_axis_2,
    input  logic [LEN_W-1:0]    i_half_len_0,
    input  logic [LEN_W-1:0]    i_half_len_1,
    input  logic [LEN_W-1:0]    i_half_len_2,
    // result request
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_inside_res,
    output logic [1:0]          o_position
);

    localparam int CW = 3*COORD_BITS;

    t_plane          w_regs [NUM_REGS];
    t_plane          w_plane [PLANE_COUNT];
    logic [CW+47:0]  w_cpad;
    logic            w_v [PLANE_COUNT+1];
    logic            w_r [PLANE_COUNT+1];
    t_query          w_q [PLANE_COUNT+1];
    logic [CW-1:0]   w_c [PLANE_COUNT+1];
    logic            w_out_rdy;
    logic            n_inside;
    t_pos            n_pos;
    logic            r_out_valid;
    logic            r_inside;
    t_pos            r_position;

    fct_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_planes (w_regs)
    );

    // lanes above the center field read as zero
    assign w_cpad = {{CW{1'b0}}, i_center};

    // build the query entering the chain
    always_comb begin
        w_q[0].action      = t_action'(i_action);
        w_q[0].radius      = i_radius;
        w_q[0].axis[0]     = i_axis_0;
        w_q[0].axis[1]     = i_axis_1;
        w_q[0].axis[2]     = i_axis_2;
        w_q[0].half_len[0] = i_half_len_0;
        w_q[0].half_len[1] = i_half_len_1;
        w_q[0].half_len[2] = i_half_len_2;
        w_q[0].st.in_view  = 1'b1;
        w_q[0].st.pos      = POS_FRONT;
    end

    assign w_c[0]  = w_cpad[CW-1:0];
    assign w_v[0]  = i_valid;
    assign o_ready = w_r[0];

    // one cell per plane
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
        if (p < NUM_REGS) begin : g_reg
            assign w_plane[p] = w_regs[p];
        end else begin : g_zero
            assign w_plane[p] = '0;
        end

        fct_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_plane  (w_plane[p]),
            .i_valid  (w_v[p]),
            .o_ready  (w_r[p]),
            .i_q      (w_q[p]),
            .i_center (w_c[p]),
            .o_valid  (w_v[p+1]),
            .i_ready  (w_r[p+1]),
            .o_q      (w_q[p+1]),
            .o_center (w_c[p+1])
        );
    end

    // final verdict by query kind
    always_comb begin
        n_inside = w_q[PLANE_COUNT].st.in_view;
        n_pos    = POS_FRONT;
        unique case (w_q[PLANE_COUNT].action)
            ACT_POINT, ACT_SPHERE: begin
                n_pos = POS_FRONT;
            end
            ACT_BOX: begin
                n_pos = w_q[PLANE_COUNT].st.pos;
            end
            default: begin
                n_inside = 1'b0;
            end
        endcase
    end

    // output register, refilled as soon as the result is taken
    assign w_out_rdy        = !r_out_valid || i_ready;
    assign w_r[PLANE_COUNT] = w_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_valid <= w_v[PLANE_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_inside   <= n_inside;
            r_position <= n_pos;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_position   = r_position;

endmodule
